/* rtl/lmcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcs_pkg
// shared sizes, command codes and the store operation type of the scanner
// ----------------------------------------------------------------------------
package lmcs_pkg;

    // matrix geometry
    localparam int NUM_COLUMNS = 16;
    localparam int NUM_ROWS    = 48;
    localparam int NUM_CELLS   = NUM_COLUMNS * NUM_ROWS;

    localparam int COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

    // transaction field widths
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 8;
    localparam int BITS_W  = 48;
    localparam int CIDX_W  = 4;

    // widths used when fitting store data to the result fields
    localparam int BEXT_W = (NUM_ROWS > BITS_W) ? NUM_ROWS : BITS_W;
    localparam int CEXT_W = (COL_W > CIDX_W) ? COL_W : CIDX_W;

    // index / NUM_ROWS by a rounded-up reciprocal, exact for any 10 bit index
    localparam int DIV_SHIFT = 20;
    localparam int DIV_RECIP = ((2 ** DIV_SHIFT) + NUM_ROWS - 1) / NUM_ROWS;
    localparam int PROD_W    = 32;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    // one operation on the frame store
    typedef struct packed {
        logic             tick;
        logic             clear;
        logic             write;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             lit;
    } t_store_op;

endpackage

/* rtl/led_matrix_column_scanner_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_column_scanner_unit
// double-buffered LED matrix column scanner, 16 columns by 48 rows
// ----------------------------------------------------------------------------
// Usage: send one transaction per command. A tick (command 0) returns one
// result carrying the current column's 48 pixels, inverted for active-low
// drive with bit 0 to be shifted first, and the column number; the scan then
// moves to the next column. A clear (command 1) turns off the whole staging
// store, a cell write (command 2) sets one staging cell at index
// column*48+row lit when the byte is nonzero; indexes above 767 are dropped.
// Clear and write return no result and mark a frame pending; the staging
// store is copied to the display store when the scan wraps after the last
// column. Every command is applied straight from the input register, so one
// transaction is taken each cycle; a tick waits only while the result
// register is still held by the consumer.
// ----------------------------------------------------------------------------
module led_matrix_column_scanner_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lmcs_pkg::CMD_W-1:0]    i_command,
    input  logic [lmcs_pkg::INDEX_W-1:0]  i_cell_index,
    input  logic [lmcs_pkg::VALUE_W-1:0]  i_cell_value,
    // column result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lmcs_pkg::BITS_W-1:0]   o_column_bits,
    output logic [lmcs_pkg::CIDX_W-1:0]   o_column_index
);
    import lmcs_pkg::*;

    // input register
    logic                r_in_valid;
    logic [CMD_W-1:0]    r_command;
    logic [INDEX_W-1:0]  r_cell_index;
    logic [VALUE_W-1:0]  r_cell_value;

    // result register
    logic                r_out_valid;
    logic [BITS_W-1:0]   r_column_bits;
    logic [CIDX_W-1:0]   r_column_index;

    logic                out_free;
    logic                advance;
    logic                is_tick;
    logic                take_in;
    t_store_op           store_op;
    logic [BITS_W-1:0]   rd_bits;
    logic [CIDX_W-1:0]   rd_col;

    // a held item moves on unless it is a tick and the result slot is full
    assign is_tick  = (r_command == CMD_TICK);
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && (!is_tick || out_free);
    assign o_ready  = !r_in_valid || advance;
    assign take_in  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_command    <= i_command;
            r_cell_index <= i_cell_index;
            r_cell_value <= i_cell_value;
        end
    end

    lmcs_cell_decode u_decode (
        .i_en         (advance),
        .i_command    (r_command),
        .i_cell_index (r_cell_index),
        .i_cell_value (r_cell_value),
        .o_op         (store_op)
    );

    // the store reads the current column while it applies the operation
    lmcs_frame_store u_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (store_op),
        .o_column_bits  (rd_bits),
        .o_column_index (rd_col)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (store_op.tick) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_op.tick) begin
            r_column_bits  <= rd_bits;
            r_column_index <= rd_col;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_column_bits  = r_column_bits;
    assign o_column_index = r_column_index;

endmodule

/* rtl/lmcs_cell_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcs_cell_decode
// turns a registered command into a frame store operation; splits the
// linear cell index into column and row and drops out-of-range writes
// ----------------------------------------------------------------------------
module lmcs_cell_decode (
    input  logic                           i_en,
    input  logic [lmcs_pkg::CMD_W-1:0]     i_command,
    input  logic [lmcs_pkg::INDEX_W-1:0]   i_cell_index,
    input  logic [lmcs_pkg::VALUE_W-1:0]   i_cell_value,
    output lmcs_pkg::t_store_op            o_op
);
    import lmcs_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] col_full;
    logic [PROD_W-1:0] row_full;
    logic              in_range;

    // column = index / NUM_ROWS, row = index - column * NUM_ROWS
    assign prod     = PROD_W'(i_cell_index) * PROD_W'(DIV_RECIP);
    assign col_full = prod >> DIV_SHIFT;
    assign row_full = PROD_W'(i_cell_index) - col_full * PROD_W'(NUM_ROWS);
    assign in_range = PROD_W'(i_cell_index) < PROD_W'(NUM_CELLS);

    always_comb begin
        o_op.tick  = 1'b0;
        o_op.clear = 1'b0;
        o_op.write = 1'b0;
        o_op.col   = col_full[COL_W-1:0];
        o_op.row   = row_full[ROW_W-1:0];
        o_op.lit   = (i_cell_value != '0);
        if (i_en) begin
            case (i_command)
                CMD_TICK:  o_op.tick  = 1'b1;
                CMD_CLEAR: o_op.clear = 1'b1;
                CMD_WRITE: o_op.write = in_range;
                default:   o_op.tick  = 1'b0;
            endcase
        end
    end

endmodule

/* rtl/lmcs_frame_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcs_frame_store
// staging and display stores, scan column counter and pending frame flag
// ----------------------------------------------------------------------------
module lmcs_frame_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lmcs_pkg::t_store_op           i_op,
    output logic [lmcs_pkg::BITS_W-1:0]   o_column_bits,
    output logic [lmcs_pkg::CIDX_W-1:0]   o_column_index
);
    import lmcs_pkg::*;

    logic [NUM_ROWS-1:0] r_display [NUM_COLUMNS];
    logic [NUM_ROWS-1:0] r_staging [NUM_COLUMNS];
    logic [COL_W-1:0]    r_scan_col;
    logic                r_pending;

    logic [BEXT_W-1:0]   bits_ext;
    logic [CEXT_W-1:0]   col_ext;
    logic                wrap;

    // inverted for active-low drive, zero above the last row
    assign bits_ext       = BEXT_W'(~r_display[r_scan_col]);
    assign o_column_bits  = bits_ext[BITS_W-1:0];
    assign col_ext        = CEXT_W'(r_scan_col);
    assign o_column_index = col_ext[CIDX_W-1:0];

    assign wrap = (r_scan_col == COL_W'(NUM_COLUMNS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_col <= '0;
            r_pending  <= 1'b0;
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                r_display[c] <= '0;
                r_staging[c] <= '0;
            end
        end else begin
            if (i_op.tick) begin
                if (wrap) begin
                    r_scan_col <= '0;
                    if (r_pending) begin
                        for (int c = 0; c < NUM_COLUMNS; c++) begin
                            r_display[c] <= r_staging[c];
                        end
                        r_pending <= 1'b0;
                    end
                end else begin
                    r_scan_col <= r_scan_col + 1'b1;
                end
            end
            if (i_op.clear) begin
                for (int c = 0; c < NUM_COLUMNS; c++) begin
                    r_staging[c] <= '0;
                end
                r_pending <= 1'b1;
            end
            if (i_op.write) begin
                r_staging[i_op.col][i_op.row] <= i_op.lit;
                r_pending <= 1'b1;
            end
        end
    end

endmodule
